// File: rtl/fcpf_pkg.sv
// ----------------------------------------------------------------------------
// fcpf_pkg
// Shared types and constants of the four-class priority fifo.
// ----------------------------------------------------------------------------
package fcpf_pkg;

	localparam int NUM_CLASSES       = 4;
	localparam int CLS_W             = 2;
	localparam int QUEUE_DEPTH_DEF   = 16;
	localparam int AGE_W             = 8;
	localparam int NAME_W            = 64;
	localparam logic [AGE_W-1:0] AGE_THRESHOLD_RST = 8'd60;

	typedef enum logic {
		OP_ENTER = 1'b0,
		OP_LEAVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_ENTERED = 2'd0,
		ST_FULL    = 2'd1,
		ST_REMOVED = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef struct packed {
		logic             wr_en;
		logic             rd_en;
		status_t          status;
		logic [CLS_W-1:0] cls;
	} ctl_t;

endpackage

// File: rtl/fcpf_if.sv
// ----------------------------------------------------------------------------
// fcpf_if
// Request and response channels of the four-class priority fifo.
// ----------------------------------------------------------------------------
interface fcpf_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [63:0] name_tag;
	logic [7:0]  age;
	logic        health;

	modport source (output valid, opcode, name_tag, age, health, input ready);
	modport sink   (input valid, opcode, name_tag, age, health, output ready);
endinterface

interface fcpf_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [1:0]  class_index;
	logic [63:0] out_name;
	logic [7:0]  out_age;
	logic        out_health;

	modport source (output valid, status, class_index, out_name, out_age, out_health,
		input ready);
	modport sink   (input valid, status, class_index, out_name, out_age, out_health,
		output ready);
endinterface

// File: rtl/four_class_priority_fifo.sv
// ----------------------------------------------------------------------------
// four_class_priority_fifo
// Four circular fifos sharing one slot memory, served in strict priority.
//
//   channel  dir  carries
//   req      in   opcode, name_tag, age, health
//   rsp      out  status, class_index, out_name, out_age, out_health
//   cfg      in   cfg_we, cfg_wdata (age_threshold)
//
// one word per cycle while rsp is not stalled; every word gives one result
// slot memory read/write and pointer update happen at the accept edge,
// read data lands in stage 1, then moves to the output register
// reset clears pointers and counts; slot memory needs no clearing
// a stalled rsp holds the output register and one more word in stage 1
// ----------------------------------------------------------------------------
module four_class_priority_fifo #(
	parameter int QUEUE_DEPTH = fcpf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	fcpf_req_if.sink                   req,
	fcpf_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [fcpf_pkg::AGE_W-1:0] cfg_wdata
);
	import fcpf_pkg::*;

	localparam int ADDR_W = $clog2(4 * QUEUE_DEPTH);
	localparam int DATA_W = NAME_W + AGE_W + 1;

	logic              accept;
	logic              advance;
	ctl_t              ctl;
	logic [ADDR_W-1:0] addr;

	logic [DATA_W-1:0] mem [4 * QUEUE_DEPTH];

	logic              valid_s1;
	status_t           status_s1;
	logic [CLS_W-1:0]  cls_s1;
	logic [DATA_W-1:0] rd_data_s1;

	logic              valid_q;

	assign advance   = valid_s1 && (!valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign accept    = req.valid && req.ready;

	fcpf_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ADDR_W      (ADDR_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.opcode    (req.opcode),
		.age       (req.age),
		.health    (req.health),
		.ctl       (ctl),
		.addr      (addr)
	);

	// slot memory
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[addr] <= {req.name_tag, req.age, req.health};
		end
		if (ctl.rd_en) begin
			rd_data_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= ctl.status;
			cls_s1    <= ctl.cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	// enter, full and empty results carry a zero payload
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp.status      <= status_s1;
			rsp.class_index <= cls_s1;
			if (status_s1 == ST_REMOVED) begin
				{rsp.out_name, rsp.out_age, rsp.out_health} <= rd_data_s1;
			end else begin
				{rsp.out_name, rsp.out_age, rsp.out_health} <= '0;
			end
		end
	end

	assign rsp.valid = valid_q;

endmodule

// File: rtl/fcpf_ctrl.sv
// ----------------------------------------------------------------------------
// fcpf_ctrl
// Class selection, per-class head/tail/count pointers and strict priority
// pick; produces the slot address and the result code for one word.
// ----------------------------------------------------------------------------
module fcpf_ctrl #(
	parameter int QUEUE_DEPTH = fcpf_pkg::QUEUE_DEPTH_DEF,
	parameter int ADDR_W      = $clog2(4 * QUEUE_DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [fcpf_pkg::AGE_W-1:0] cfg_wdata,
	input  logic                       accept,
	input  logic                       opcode,
	input  logic [fcpf_pkg::AGE_W-1:0] age,
	input  logic                       health,
	output fcpf_pkg::ctl_t             ctl,
	output logic [ADDR_W-1:0]          addr
);
	import fcpf_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [AGE_W-1:0] threshold_q;
	logic [PTR_W-1:0] head_q [NUM_CLASSES];
	logic [PTR_W-1:0] tail_q [NUM_CLASSES];
	logic [CNT_W-1:0] count_q [NUM_CLASSES];

	logic             elder;
	logic [CLS_W-1:0] cls_in;
	logic [CLS_W-1:0] cls_srv;
	logic             found;
	logic             full;
	logic [CLS_W-1:0] cls_sel;
	logic [PTR_W-1:0] ptr_sel;

	function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1))
			return '0;
		return p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= AGE_THRESHOLD_RST;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	assign elder  = (age >= threshold_q);
	assign cls_in = {~health, ~elder};
	assign full   = (count_q[cls_in] == CNT_W'(QUEUE_DEPTH));

	// strict priority: lowest class with content
	always_comb begin
		found   = 1'b0;
		cls_srv = '0;
		for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
			if (count_q[i] != '0) begin
				found   = 1'b1;
				cls_srv = CLS_W'(i);
			end
		end
	end

	always_comb begin
		ctl = '0;
		if (opcode == OP_ENTER) begin
			cls_sel    = cls_in;
			ptr_sel    = tail_q[cls_in];
			ctl.cls    = cls_in;
			ctl.status = full ? ST_FULL : ST_ENTERED;
			ctl.wr_en  = accept && !full;
		end else begin
			cls_sel    = cls_srv;
			ptr_sel    = head_q[cls_srv];
			ctl.cls    = found ? cls_srv : '0;
			ctl.status = found ? ST_REMOVED : ST_EMPTY;
			ctl.rd_en  = accept && found;
		end
		addr = ADDR_W'(ADDR_W'(cls_sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr_sel));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (ctl.wr_en) begin
			tail_q[cls_in]  <= wrap_next(tail_q[cls_in]);
			count_q[cls_in] <= count_q[cls_in] + CNT_W'(1);
		end else if (ctl.rd_en) begin
			head_q[cls_srv]  <= wrap_next(head_q[cls_srv]);
			count_q[cls_srv] <= count_q[cls_srv] - CNT_W'(1);
		end
	end

endmodule
